// ===== hdl/plcs_pkg.sv =====
// Shared constants and types for the piecewise-linear curve sampler.
package plcs_pkg;

    localparam int Depth = 256;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = IdxW + 1;
    localparam int MinSamples = 2;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NOT_INC = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_SHORT = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_QUERY,
        KIND_REJECT
    } kind_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        kind_t kind;
        logic [1:0] status;
        logic first_row;
        logic [31:0] time_point;
        logic [31:0] distance_value;
        logic [31:0] vertical_value;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CLAMP,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_PAIR_LO,
        ST_PAIR_HI,
        ST_DIVIDE,
        ST_MUL,
        ST_ROUND,
        ST_OUT
    } back_state_t;

endpackage

// ===== hdl/plcs_front.sv =====
// Front part: accepts input words, tracks table fill/time order, classifies items.
module plcs_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [1:0] s_tuser,    // operation, first_row
    input  logic [95:0] s_tdata,   // time_point, distance_value, vertical_value
    output logic q_valid,
    input  logic q_ready,
    output plcs_pkg::cmd_t q_cmd
);

    logic [plcs_pkg::CntW-1:0] count_reg, count_next;
    logic bad_reg, bad_next;
    logic [31:0] last_t_reg, last_t_next;
    logic valid_reg, valid_next;
    plcs_pkg::cmd_t cmd_reg, cmd_next;
    logic [plcs_pkg::CntW-1:0] base_cnt;
    logic base_bad;
    logic take;

    assign s_tready = !valid_reg || q_ready;
    assign take = s_tvalid && s_tready;
    assign q_valid = valid_reg;
    assign q_cmd = cmd_reg;

    always_comb begin
        count_next = count_reg;
        bad_next = bad_reg;
        last_t_next = last_t_reg;
        valid_next = valid_reg && !q_ready;
        cmd_next = cmd_reg;
        base_cnt = s_tuser[1] ? '0 : count_reg;
        base_bad = s_tuser[1] ? 1'b0 : bad_reg;
        if (take) begin
            valid_next = 1'b1;
            cmd_next.first_row = s_tuser[1];
            cmd_next.time_point = s_tdata[31:0];
            cmd_next.distance_value = s_tdata[63:32];
            cmd_next.vertical_value = s_tdata[95:64];
            cmd_next.status = plcs_pkg::STAT_OK;
            if (!s_tuser[0]) begin
                count_next = base_cnt;
                bad_next = base_bad;
                cmd_next.kind = plcs_pkg::KIND_REJECT;
                if (base_cnt >= plcs_pkg::CntW'(plcs_pkg::Depth)) begin
                    cmd_next.status = plcs_pkg::STAT_FULL;
                end else if (base_cnt != '0 &&
                             $signed(s_tdata[31:0]) <= $signed(last_t_reg)) begin
                    cmd_next.status = plcs_pkg::STAT_NOT_INC;
                    bad_next = 1'b1;
                end else begin
                    cmd_next.kind = plcs_pkg::KIND_LOAD;
                    count_next = base_cnt + 1'b1;
                    last_t_next = s_tdata[31:0];
                end
            end else if (bad_reg ||
                         count_reg < plcs_pkg::CntW'(plcs_pkg::MinSamples)) begin
                cmd_next.kind = plcs_pkg::KIND_REJECT;
                cmd_next.status = plcs_pkg::STAT_SHORT;
            end else begin
                cmd_next.kind = plcs_pkg::KIND_QUERY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bad_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            bad_reg <= bad_next;
            valid_reg <= valid_next;
        end
        last_t_reg <= last_t_next;
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/plcs_queue.sv =====
// Two-entry queue between the front and back parts.
module plcs_queue (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  plcs_pkg::cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output plcs_pkg::cmd_t out_cmd
);

    plcs_pkg::cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= in_cmd;
    end

endmodule

// ===== hdl/plcs_back.sv =====
// Back part: breakpoint memory, binary search, serial divide and interpolation.
module plcs_back (
    input  logic aclk,
    input  logic aresetn,
    input  logic c_valid,
    output logic c_ready,
    input  plcs_pkg::cmd_t c_cmd,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [127:0] m_tdata,
    output logic [1:0] m_tuser
);

    localparam int IW = plcs_pkg::IdxW;
    localparam int CW = plcs_pkg::CntW;

    logic [95:0] mem [plcs_pkg::Depth];
    logic [95:0] rd_reg;
    logic [IW-1:0] rd_addr;
    logic rd_en;

    plcs_pkg::back_state_t state_reg, state_next;
    plcs_pkg::cmd_t cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] last_t_reg, last_d_reg;
    logic [IW-1:0] lo_reg, hi_reg, mid;
    logic [95:0] lo_e_reg, hi_e_reg;
    logic [5:0] step_reg;
    logic [32:0] rem_reg, span_reg;
    logic [30:0] quo_reg;
    logic [63:0] pd_reg, pv_reg;
    logic [31:0] dout_reg, vout_reg;
    logic [1:0] stat_reg;
    logic out_v_reg;
    logic [31:0] qt;
    logic [33:0] rem_sh;
    logic c_take;

    assign qt = cmd_reg.time_point;
    assign mid = IW'((CW'(lo_reg) + CW'(hi_reg)) >> 1);
    // hold new commands until the previous result word has left
    assign c_ready = (state_reg == plcs_pkg::ST_IDLE) && !out_v_reg;
    assign c_take = c_valid && c_ready;
    assign m_tvalid = out_v_reg;
    assign m_tuser = stat_reg;
    assign m_tdata = {last_d_reg, last_t_reg, vout_reg, dout_reg};
    assign rem_sh = {rem_reg, 1'b0};

    function automatic logic [31:0] blend(input logic [31:0] lo, input logic [63:0] p,
                                          input logic neg);
        logic [32:0] q;
        q = 33'((p + 64'(1) * (64'd1 << 30)) >> 31);
        return neg ? lo - q[31:0] : lo + q[31:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plcs_pkg::ST_IDLE: if (c_take) begin
                state_next = (c_cmd.kind == plcs_pkg::KIND_QUERY) ?
                             plcs_pkg::ST_RD_FIRST : plcs_pkg::ST_OUT;
            end
            plcs_pkg::ST_RD_FIRST: state_next = plcs_pkg::ST_RD_LAST;
            plcs_pkg::ST_RD_LAST: state_next = plcs_pkg::ST_CLAMP;
            plcs_pkg::ST_CLAMP: begin
                if ($signed(qt) <= $signed(lo_e_reg[31:0]) ||
                    $signed(qt) >= $signed(rd_reg[31:0])) state_next = plcs_pkg::ST_OUT;
                else state_next = plcs_pkg::ST_SEARCH_RD;
            end
            plcs_pkg::ST_SEARCH_RD: begin
                if (CW'(hi_reg) - CW'(lo_reg) > CW'(1)) state_next = plcs_pkg::ST_SEARCH_CMP;
                else state_next = plcs_pkg::ST_PAIR_LO;
            end
            plcs_pkg::ST_SEARCH_CMP: state_next = plcs_pkg::ST_SEARCH_RD;
            plcs_pkg::ST_PAIR_LO: state_next = plcs_pkg::ST_PAIR_HI;
            plcs_pkg::ST_PAIR_HI: state_next = plcs_pkg::ST_DIVIDE;
            plcs_pkg::ST_DIVIDE: if (step_reg == 6'd30) state_next = plcs_pkg::ST_MUL;
            plcs_pkg::ST_MUL: state_next = plcs_pkg::ST_ROUND;
            plcs_pkg::ST_ROUND: state_next = plcs_pkg::ST_OUT;
            plcs_pkg::ST_OUT: if (!out_v_reg || m_tready) state_next = plcs_pkg::ST_IDLE;
            default: state_next = plcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            plcs_pkg::ST_RD_FIRST: rd_en = 1'b1;
            plcs_pkg::ST_RD_LAST: begin
                rd_en = 1'b1;
                rd_addr = IW'(cnt_reg - 1'b1);
            end
            plcs_pkg::ST_SEARCH_RD: begin
                rd_en = 1'b1;
                rd_addr = (CW'(hi_reg) - CW'(lo_reg) > CW'(1)) ? mid : lo_reg;
            end
            plcs_pkg::ST_PAIR_LO: begin
                rd_en = 1'b1;
                rd_addr = hi_reg;
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rd_reg <= mem[rd_addr];
        if (c_take && c_cmd.kind == plcs_pkg::KIND_LOAD) begin
            mem[c_cmd.first_row ? IW'(0) : IW'(cnt_reg)] <=
                {c_cmd.vertical_value, c_cmd.distance_value, c_cmd.time_point};
        end
    end

    always_ff @(posedge aclk) begin
        logic [32:0] dd, dv;
        logic [31:0] frac;
        if (!aresetn) begin
            state_reg <= plcs_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_v_reg <= 1'b0;
            last_t_reg <= '0;
            last_d_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == plcs_pkg::ST_OUT) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                plcs_pkg::ST_IDLE: if (c_take) begin
                    cmd_reg <= c_cmd;
                    stat_reg <= c_cmd.status;
                    dout_reg <= '0;
                    vout_reg <= '0;
                    if (c_cmd.kind == plcs_pkg::KIND_LOAD) begin
                        cnt_reg <= (c_cmd.first_row ? CW'(0) : cnt_reg) + 1'b1;
                        last_t_reg <= c_cmd.time_point;
                        last_d_reg <= c_cmd.distance_value;
                    end else if (c_cmd.first_row && c_cmd.kind == plcs_pkg::KIND_REJECT &&
                                 c_cmd.status != plcs_pkg::STAT_SHORT) begin
                        // emptied by first_row, then rejected
                        cnt_reg <= '0;
                        last_t_reg <= '0;
                        last_d_reg <= '0;
                    end
                end
                plcs_pkg::ST_RD_LAST: lo_e_reg <= rd_reg;
                plcs_pkg::ST_CLAMP: begin
                    hi_e_reg <= rd_reg;
                    lo_reg <= '0;
                    hi_reg <= IW'(cnt_reg - 1'b1);
                    if ($signed(qt) <= $signed(lo_e_reg[31:0])) begin
                        dout_reg <= lo_e_reg[63:32];
                        vout_reg <= lo_e_reg[95:64];
                    end else begin
                        dout_reg <= rd_reg[63:32];
                        vout_reg <= rd_reg[95:64];
                    end
                end
                plcs_pkg::ST_SEARCH_CMP: begin
                    if ($signed(rd_reg[31:0]) > $signed(qt)) hi_reg <= mid;
                    else lo_reg <= mid;
                end
                plcs_pkg::ST_PAIR_LO: begin
                    lo_e_reg <= rd_reg;
                    step_reg <= '0;
                    quo_reg <= '0;
                    rem_reg <= 33'($signed(qt)) - 33'($signed(rd_reg[31:0]));
                end
                plcs_pkg::ST_DIVIDE: begin
                    if (step_reg == '0) begin
                        hi_e_reg <= rd_reg;
                        span_reg <= 33'($signed(rd_reg[31:0])) -
                                    33'($signed(lo_e_reg[31:0]));
                        if (rem_sh >= {1'b0, 33'($signed(rd_reg[31:0])) -
                                       33'($signed(lo_e_reg[31:0]))}) begin
                            rem_reg <= 33'(rem_sh - {1'b0, 33'($signed(rd_reg[31:0])) -
                                       33'($signed(lo_e_reg[31:0]))});
                            quo_reg <= 31'd1;
                        end else begin
                            rem_reg <= rem_sh[32:0];
                            quo_reg <= 31'd0;
                        end
                    end else if (rem_sh >= {1'b0, span_reg}) begin
                        rem_reg <= 33'(rem_sh - {1'b0, span_reg});
                        quo_reg <= {quo_reg[29:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[32:0];
                        quo_reg <= {quo_reg[29:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                end
                plcs_pkg::ST_MUL: begin
                    frac = {1'b0, quo_reg};
                    dd = 33'($signed(hi_e_reg[63:32])) - 33'($signed(lo_e_reg[63:32]));
                    dv = 33'($signed(hi_e_reg[95:64])) - 33'($signed(lo_e_reg[95:64]));
                    pd_reg <= 64'(dd[32] ? 33'(-dd) : dd) * 64'(frac);
                    pv_reg <= 64'(dv[32] ? 33'(-dv) : dv) * 64'(frac);
                    cmd_reg.first_row <= dd[32];
                    cmd_reg.distance_value <= {31'd0, dv[32]};
                end
                plcs_pkg::ST_ROUND: begin
                    dout_reg <= blend(lo_e_reg[63:32], pd_reg, cmd_reg.first_row);
                    vout_reg <= blend(lo_e_reg[95:64], pv_reg, cmd_reg.distance_value[0]);
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/piecewise_linear_curve_sampler.sv =====
// Top level of the piecewise-linear curve sampler.
//
//  channel  dir  tdata (low bit up)                                tuser
//  s_       in   time_point, distance_value, vertical_value (96)   operation, first_row
//  m_       out  distance_out, vertical_out, last_time,
//                total_distance (128)                              status
//
// A load or rejected item goes straight to the result word; a clamped query first reads the
// first and last breakpoints, and an interpolated query adds the binary search over the
// single-port breakpoint memory, the 31-step serial divider, multiply and rounding.
// The front register and the queue lie between input accept and the back part.
// Reset clears fill count and bad flag; the memory is not cleared.
// The back part takes the next word only once its result word is accepted; the front
// part and queue hold up to three words ahead, so input stalls only when all are full.
module piecewise_linear_curve_sampler (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [95:0] s_tdata,   // time_point, distance_value, vertical_value
    input  logic [1:0] s_tuser,    // operation, first_row
    output logic m_tvalid,
    input  logic m_tready,
    output logic [127:0] m_tdata,  // distance_out, vertical_out, last_time, total_distance
    output logic [1:0] m_tuser     // status
);

    logic f_valid, f_ready, b_valid, b_ready;
    plcs_pkg::cmd_t f_cmd, b_cmd;

    // classify words against the running fill count
    plcs_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
    );

    // decouple classification from execution
    plcs_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    // store, search, divide, interpolate
    plcs_back u_back (
        .aclk, .aresetn,
        .c_valid(b_valid), .c_ready(b_ready), .c_cmd(b_cmd),
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

endmodule

// ===== tb/plcs_checker.sv =====
// Checker for the curve sampler: watches both channels, predicts each result word and compares.
module plcs_checker (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tready,
    input  logic [95:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic m_tvalid,
    input  logic m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0] m_tuser,
    output int fail_count,
    output int pending_count
);

    typedef struct packed {
        logic [1:0] status;
        logic [31:0] dist_out;
        logic [31:0] vert;
        logic [31:0] last_t;
        logic [31:0] total_d;
    } curve_result_t;

    logic signed [31:0] bp_time [plcs_pkg::Depth];
    logic signed [31:0] bp_dist [plcs_pkg::Depth];
    logic signed [31:0] bp_vert [plcs_pkg::Depth];
    int bp_count;
    bit bp_bad;
    curve_result_t expected_q[$];

    // Round-to-nearest blend of two breakpoint values by a Q0.31 fraction.
    function automatic logic [31:0] mix_value(longint lo, longint hi, longint unsigned frac);
        longint delta;
        longint unsigned mag;
        longint unsigned q;
        delta = hi - lo;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        q = (mag * frac + (64'd1 << 30)) >> 31;
        return (delta < 0) ? 32'(lo - longint'(q)) : 32'(lo + longint'(q));
    endfunction

    function automatic curve_result_t sample_curve(logic [1:0] user, logic [95:0] data);
        curve_result_t r;
        logic signed [31:0] t;
        int lo, hi, mid;
        longint unsigned span, off, frac;
        r = '0;
        t = data[31:0];
        if (!user[0]) begin
            if (user[1]) begin
                bp_count = 0;
                bp_bad = 0;
            end
            if (bp_count >= plcs_pkg::Depth) begin
                r.status = plcs_pkg::STAT_FULL;
            end else if (bp_count > 0 && t <= bp_time[bp_count-1]) begin
                r.status = plcs_pkg::STAT_NOT_INC;
                bp_bad = 1;
            end else begin
                bp_time[bp_count] = t;
                bp_dist[bp_count] = data[63:32];
                bp_vert[bp_count] = data[95:64];
                bp_count++;
            end
        end else if (bp_bad || bp_count < plcs_pkg::MinSamples) begin
            r.status = plcs_pkg::STAT_SHORT;
        end else if (t <= bp_time[0]) begin
            r.dist_out = bp_dist[0];
            r.vert = bp_vert[0];
        end else if (t >= bp_time[bp_count-1]) begin
            r.dist_out = bp_dist[bp_count-1];
            r.vert = bp_vert[bp_count-1];
        end else begin
            lo = 0;
            hi = bp_count - 1;
            while (hi - lo > 1) begin
                mid = lo + (hi - lo) / 2;
                if (bp_time[mid] > t) hi = mid;
                else lo = mid;
            end
            span = longint'(bp_time[hi]) - longint'(bp_time[lo]);
            off = longint'(t) - longint'(bp_time[lo]);
            frac = (off << 31) / span;
            r.dist_out = mix_value(bp_dist[lo], bp_dist[hi], frac);
            r.vert = mix_value(bp_vert[lo], bp_vert[hi], frac);
        end
        if (bp_count > 0) begin
            r.last_t = bp_time[bp_count-1];
            r.total_d = bp_dist[bp_count-1];
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        curve_result_t want;
        if (!aresetn) begin
            bp_count = 0;
            bp_bad = 0;
            fail_count = 0;
            pending_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected word", m_tdata[31:0], 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser != want.status) report("status", m_tuser, want.status);
                    if (m_tdata[31:0] != want.dist_out)
                        report("distance", m_tdata[31:0], want.dist_out);
                    if (m_tdata[63:32] != want.vert)
                        report("vertical", m_tdata[63:32], want.vert);
                    if (m_tdata[95:64] != want.last_t)
                        report("last time", m_tdata[95:64], want.last_t);
                    if (m_tdata[127:96] != want.total_d)
                        report("total distance", m_tdata[127:96], want.total_d);
                end
            end
            if (s_tvalid && s_tready) expected_q = {expected_q, sample_curve(s_tuser, s_tdata)};
            pending_count = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the curve sampler: clock, reset, stimulus and verdict.
module tb_top;

    localparam int unsigned CycleLimit = 2_000_000;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [95:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;
    int fail_count;
    int pending_count;
    int unsigned cycle_count = 0;
    bit sink_calm;

    // operation in tuser bit 0, first_row in bit 1
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    piecewise_linear_curve_sampler uut (.*);

    plcs_checker chk (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop on a hung design.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random idle gap: mostly short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls, with calm stretches where it stays ready.
    initial begin
        int g;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            m_tready <= 1;
            if (sink_calm) begin
                @(posedge aclk);
            end else begin
                g = $urandom_range(1, 8);
                repeat (g) @(posedge aclk);
                g = pick_gap();
                if (g > 0) begin
                    m_tready <= 0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
    end

    // Push one word and hold it until accepted, then maybe idle.
    task automatic send_word(logic op, logic first, logic [31:0] t, logic [31:0] d,
                             logic [31:0] v, bit gaps);
        int g;
        s_tvalid <= 1;
        s_tuser <= {first, op};
        s_tdata <= {v, d, t};
        do @(posedge aclk); while (!s_tready);
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            s_tdata <= {$urandom, $urandom, $urandom};
            repeat (g) @(posedge aclk);
        end
    endtask

    // Well-formed curve with random content, then queries around it.
    task automatic random_curve(int n, int queries, bit gaps);
        logic signed [31:0] t;
        logic signed [31:0] t0;
        int step;
        t = $urandom_range(0, 3) == 0 ? 32'sh8000_0000 + $urandom_range(0, 50)
                                      : $signed($urandom) >>> 2;
        t0 = t;
        step = $urandom_range(0, 1) ? 2 : 1 << $urandom_range(4, 22);
        for (int i = 0; i < n; i++) begin
            send_word(OP_LOAD, i == 0, t, $urandom, $urandom, gaps);
            if ($urandom_range(0, 39) == 0) begin
                send_word(OP_LOAD, 0, t - $urandom_range(0, 5), $urandom, $urandom, gaps);
            end
            t = t + $urandom_range(1, step);
        end
        for (int i = 0; i < queries; i++) begin
            case ($urandom_range(0, 9))
                0: send_word(OP_QUERY, 1'($urandom), $urandom, $urandom, $urandom, gaps);
                1: send_word(OP_QUERY, 0, t0 - $urandom_range(0, 2), 0, 0, gaps);
                2: send_word(OP_QUERY, 0, t + $urandom_range(0, 2), 0, 0, gaps);
                default: send_word(OP_QUERY, 1'($urandom), t0 + $urandom_range(0, t - t0),
                                   $urandom, $urandom, gaps);
            endcase
        end
    endtask

    initial begin
        int n;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        aresetn = 0;
        sink_calm = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty and short table, extremes, bad time, clamping, ties.
        send_word(OP_QUERY, 0, 0, 0, 0, 0);
        send_word(OP_LOAD, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_word(OP_QUERY, 1, 0, '1, '1, 0);
        send_word(OP_LOAD, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_word(OP_QUERY, 0, 32'h8000_0000, 0, 0, 0);
        send_word(OP_QUERY, 0, 32'h7fff_ffff, 0, 0, 0);
        send_word(OP_QUERY, 0, 32'h0000_0000, 0, 0, 0);
        send_word(OP_QUERY, 0, 32'h8000_0001, 0, 0, 0);
        send_word(OP_QUERY, 0, 32'h7fff_fffe, 0, 0, 0);
        send_word(OP_LOAD, 0, 32'h7fff_ffff, 0, 0, 0);   // equal time marks table bad
        send_word(OP_QUERY, 0, 0, 0, 0, 0);
        send_word(OP_LOAD, 1, 0, 0, 0, 0);
        send_word(OP_LOAD, 0, 2, 1, 32'hffff_ffff, 0);   // half-LSB rounding ties
        send_word(OP_QUERY, 0, 1, 0, 0, 0);
        send_word(OP_LOAD, 0, 5, 7, 32'hffff_fff0, 0);
        send_word(OP_QUERY, 0, 3, 0, 0, 0);
        send_word(OP_QUERY, 0, 4, 0, 0, 0);
        send_word(OP_LOAD, 0, 1, 0, 0, 0);               // decreasing time
        send_word(OP_LOAD, 0, 9, 3, 3, 0);               // still appended into bad table
        send_word(OP_QUERY, 0, 6, 0, 0, 0);

        // Fill to capacity, overflow, and query the full table.
        random_curve(plcs_pkg::Depth, 0, 1);
        send_word(OP_LOAD, 0, 32'h7fff_ffff, 0, 0, 1);
        send_word(OP_LOAD, 0, 32'h8000_0000, 0, 0, 1);
        for (int i = 0; i < 20; i++) send_word(OP_QUERY, 0, $urandom, 0, 0, 1);

        // Drain fully before going on.
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);

        sink_calm = 1;
        random_curve(12, 30, 0);
        sink_calm = 0;

        // Random curves, mostly small.
        for (int k = 0; k < 78; k++) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
            random_curve(n, $urandom_range(2, 12), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                send_word(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, 1);
        end

        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
